// ----- rtl/tmpr_pkg.sv -----
// ----------------------------------------------------------------------------
// tmpr_pkg
// Shared types and constants for the tile-map pixel renderer.
// ----------------------------------------------------------------------------
package tmpr_pkg;

    typedef enum logic [2:0] {
        OP_WR_TILE = 3'd0,
        OP_RD_TILE = 3'd1,
        OP_WR_CHAR = 3'd2,
        OP_WR_PAL  = 3'd3,
        OP_RENDER  = 3'd4
    } op_t;

    localparam int unsigned CH_W      = 10;
    localparam int unsigned XFLIP_BIT = 10;
    localparam int unsigned YFLIP_BIT = 11;
    localparam int unsigned CHAR_BYTES = 64;
    localparam int unsigned PAL_DEPTH  = 256;
    localparam logic [3:0]  NIB_MASK   = 4'hF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

    // config register map
    localparam int unsigned PADDR_W  = 3;
    localparam logic        REG_MASK = 1'b0;

    typedef struct packed {
        logic        wr;
        logic        rd;
        logic        display;
        logic [1:0]  plane;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] wdata;
    } tile_req_t;

    typedef struct packed {
        logic        en;
        logic        display;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } char_wr_t;

    typedef struct packed {
        logic            en;
        logic            display;
        logic [CH_W-1:0] ch;
        logic [2:0]      tx;
        logic [2:0]      ty;
        logic            wide;
    } char_rd_t;

    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [23:0] color;
    } pal_wr_t;

endpackage

// ----- rtl/tile_map_pixel_renderer.sv -----
// Writes complete in the accept cycle. A tile read registers the tile map read,
// then loads the output register. A render registers the tile map read, the
// character number fold, the character store read and the palette read in turn,
// then loads the output register; both wait until the output register is free.
// Throughput: one item at a time; a new item is taken once the previous one has left the sequencer.
// Reset clears the sequencer, output valid and the 8bpp plane mask; memories are undefined.
// ----------------------------------------------------------------------------
// tile_map_pixel_renderer
// Tile-map display engine: tile map, character store and palette memories with
// a render sequencer that chains the three reads per pixel.
// ----------------------------------------------------------------------------
module tile_map_pixel_renderer #(
    parameter int DISPLAYS   = 2,
    parameter int PLANES     = 4,
    parameter int MAP_SIDE   = 32,
    parameter int CHARACTERS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // operation[2:0] display[3] plane[5:4] col[13:6] row[21:14]
    // address[37:22] data[61:38] zero[63:62]
    input  logic [63:0]                  s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tile_entry[15:0] red[23:16] green[31:24] blue[39:32] alpha[47:40]
    output logic [47:0]                  m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmpr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tmpr_pkg::*;

    localparam int RECIP_SH = 16;
    localparam int CH_RECIP = (1 << RECIP_SH) / CHARACTERS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TILE,
        ST_CHAR,
        ST_PIX,
        ST_PAL
    } state_t;

    state_t      state_reg;
    logic [7:0]  mask_reg;
    logic        disp_reg;
    logic [1:0]  plane_reg;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [15:0] ent_reg;
    logic [4:0]  q_reg;
    logic [7:0]  idx_reg;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [47:0] m_tdata_reg;

    op_t         in_op;
    logic        in_disp;
    logic [1:0]  in_plane;
    logic [7:0]  in_col;
    logic [7:0]  in_row;
    logic [15:0] in_addr;
    logic [23:0] in_data;
    logic        accept;
    logic        out_free;

    tile_req_t   tile_req;
    logic [15:0] tile_rdata;
    char_wr_t    char_wr;
    char_rd_t    char_rd;
    logic [7:0]  char_pix;
    pal_wr_t     pal_wr;
    logic        pal_rd_en;
    logic [7:0]  pal_raddr;
    logic [23:0] pal_rdata;

    logic [20:0] q_prod;
    logic [15:0] qc;
    logic [11:0] rem_raw;
    logic [11:0] rem_fix;
    logic [31:0] unit_lin;
    logic        unit_ok;
    logic        wide;
    logic [7:0]  pix_idx;
    logic        cfg_wr;

    assign in_op    = op_t'(s_tdata[2:0]);
    assign in_disp  = s_tdata[3];
    assign in_plane = s_tdata[5:4];
    assign in_col   = s_tdata[13:6];
    assign in_row   = s_tdata[21:14];
    assign in_addr  = s_tdata[37:22];
    assign in_data  = s_tdata[61:38];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MASK);
    assign prdata = (paddr[2] == REG_MASK) ? {24'b0, mask_reg} : '0;

    always_comb
    begin
        unit_lin = 32'(disp_reg) * 32'(PLANES) + 32'(plane_reg);
        unit_ok  = (32'(disp_reg) < 32'(DISPLAYS)) && (32'(plane_reg) < 32'(PLANES));
        wide     = (unit_lin < 32'd8) && mask_reg[unit_lin[2:0]];

        // character number mod CHARACTERS by reciprocal, one correction step
        q_prod   = 21'(tile_rdata[CH_W-1:0]) * 21'(CH_RECIP);
        qc       = 16'(q_reg) * 16'(CHARACTERS);
        rem_raw  = 12'(ent_reg[CH_W-1:0]) - qc[11:0];
        rem_fix  = (rem_raw >= 12'(CHARACTERS)) ? rem_raw - 12'(CHARACTERS) : rem_raw;

        pix_idx  = unit_ok ? char_pix : 8'd0;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (((state_reg == ST_READ) || (state_reg == ST_PAL)) && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_comb
    begin
        tile_req.wr      = accept && (in_op == OP_WR_TILE);
        tile_req.rd      = accept && ((in_op == OP_RD_TILE) || (in_op == OP_RENDER));
        tile_req.display = in_disp;
        tile_req.plane   = in_plane;
        tile_req.col     = (in_op == OP_RENDER) ? {3'b0, in_col[7:3]} : in_col;
        tile_req.row     = (in_op == OP_RENDER) ? {3'b0, in_row[7:3]} : in_row;
        tile_req.wdata   = in_data[15:0];

        char_wr.en       = accept && (in_op == OP_WR_CHAR);
        char_wr.display  = in_disp;
        char_wr.addr     = in_addr;
        char_wr.wdata    = in_data[7:0];

        char_rd.en       = (state_reg == ST_CHAR);
        char_rd.display  = disp_reg;
        char_rd.ch       = rem_fix[CH_W-1:0];
        char_rd.tx       = col_reg[2:0] ^ {3{ent_reg[XFLIP_BIT]}};
        char_rd.ty       = row_reg[2:0] ^ {3{ent_reg[YFLIP_BIT]}};
        char_rd.wide     = wide;

        pal_wr.en        = accept && (in_op == OP_WR_PAL);
        pal_wr.addr      = in_addr;
        pal_wr.color     = in_data;

        pal_rd_en        = (state_reg == ST_PIX);
        pal_raddr        = pix_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                mask_reg <= pwdata[7:0];
            end
            m_tvalid_reg <= m_tvalid_next;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        disp_reg  <= in_disp;
                        plane_reg <= in_plane;
                        col_reg   <= in_col;
                        row_reg   <= in_row;
                        if (in_op == OP_RD_TILE)
                        begin
                            state_reg <= ST_READ;
                        end
                        else if (in_op == OP_RENDER)
                        begin
                            state_reg <= ST_TILE;
                        end
                    end
                end
                ST_READ:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {32'b0, tile_rdata};
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_TILE:
                begin
                    ent_reg   <= tile_rdata;
                    q_reg     <= q_prod[20:RECIP_SH];
                    state_reg <= ST_CHAR;
                end
                ST_CHAR:
                begin
                    state_reg <= ST_PIX;
                end
                ST_PIX:
                begin
                    idx_reg   <= pix_idx;
                    state_reg <= ST_PAL;
                end
                ST_PAL:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {(idx_reg == 8'd0) ? ALPHA_CLEAR : ALPHA_OPAQUE,
                                         pal_rdata[7:0], pal_rdata[15:8],
                                         pal_rdata[23:16], 16'b0};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tmpr_tile_store #(
        .DISPLAYS (DISPLAYS),
        .PLANES   (PLANES),
        .MAP_SIDE (MAP_SIDE)
    ) u_tile (
        .clk   (clk),
        .req   (tile_req),
        .rdata (tile_rdata)
    );

    tmpr_char_store #(
        .DISPLAYS   (DISPLAYS),
        .CHARACTERS (CHARACTERS)
    ) u_char (
        .clk (clk),
        .wr  (char_wr),
        .rd  (char_rd),
        .pix (char_pix)
    );

    tmpr_palette u_pal (
        .clk   (clk),
        .wr    (pal_wr),
        .rd_en (pal_rd_en),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

endmodule

// ----- rtl/tmpr_tile_store.sv -----
// ----------------------------------------------------------------------------
// tmpr_tile_store
// Tile map memory for all displays and planes, with range checking.
// ----------------------------------------------------------------------------
module tmpr_tile_store #(
    parameter int DISPLAYS = 2,
    parameter int PLANES   = 4,
    parameter int MAP_SIDE = 32
) (
    input  logic                clk,
    input  tmpr_pkg::tile_req_t req,
    output logic [15:0]         rdata
);
    import tmpr_pkg::*;

    localparam int DEPTH = DISPLAYS * PLANES * MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rdata_reg;
    logic          hit_reg;
    logic          in_map;
    logic [31:0]   lin;
    logic [AW-1:0] addr;

    always_comb
    begin
        in_map = (32'(req.display) < 32'(DISPLAYS)) && (32'(req.plane) < 32'(PLANES)) &&
                 (32'(req.col) < 32'(MAP_SIDE)) && (32'(req.row) < 32'(MAP_SIDE));
        lin    = ((32'(req.display) * 32'(PLANES) + 32'(req.plane)) * 32'(MAP_SIDE)
                  + 32'(req.row)) * 32'(MAP_SIDE) + 32'(req.col);
        addr   = lin[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.wr && in_map)
        begin
            mem[addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[addr];
            hit_reg   <= in_map;
        end
    end

    // off-map reads return a blank entry
    assign rdata = hit_reg ? rdata_reg : '0;

endmodule

// ----- rtl/tmpr_char_store.sv -----
// ----------------------------------------------------------------------------
// tmpr_char_store
// Character byte memory per display; fetches one pixel index in 4bpp or 8bpp.
// ----------------------------------------------------------------------------
module tmpr_char_store #(
    parameter int DISPLAYS   = 2,
    parameter int CHARACTERS = 1024
) (
    input  logic               clk,
    input  tmpr_pkg::char_wr_t wr,
    input  tmpr_pkg::char_rd_t rd,
    output logic [7:0]         pix
);
    import tmpr_pkg::*;

    localparam int STORE_BYTES = CHARACTERS * CHAR_BYTES;
    localparam int DEPTH       = DISPLAYS * STORE_BYTES;
    localparam int AW          = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    byte_reg;
    logic          wide_reg;
    logic          hi_reg;
    logic          wr_ok;
    logic [31:0]   wr_lin;
    logic [31:0]   rd_lin;
    logic [31:0]   rd_off;

    always_comb
    begin
        wr_ok  = (32'(wr.display) < 32'(DISPLAYS)) && (32'(wr.addr) < 32'(STORE_BYTES));
        wr_lin = 32'(wr.display) * 32'(STORE_BYTES) + 32'(wr.addr);
        if (rd.wide)
        begin
            rd_off = 32'({rd.ch, rd.ty, rd.tx});
        end
        else
        begin
            rd_off = 32'({rd.ch, rd.ty, rd.tx[2:1]});
        end
        rd_lin = 32'(rd.display) * 32'(STORE_BYTES) + rd_off;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_ok)
        begin
            mem[wr_lin[AW-1:0]] <= wr.wdata;
        end
        if (rd.en)
        begin
            byte_reg <= mem[rd_lin[AW-1:0]];
            wide_reg <= rd.wide;
            hi_reg   <= rd.tx[0];
        end
    end

    // 4bpp: low nibble is the even column
    always_comb
    begin
        if (wide_reg)
        begin
            pix = byte_reg;
        end
        else if (hi_reg)
        begin
            pix = {4'b0, byte_reg[7:4] & NIB_MASK};
        end
        else
        begin
            pix = {4'b0, byte_reg[3:0] & NIB_MASK};
        end
    end

endmodule

// ----- rtl/tmpr_palette.sv -----
// ----------------------------------------------------------------------------
// tmpr_palette
// Shared 256-entry RGB palette memory.
// ----------------------------------------------------------------------------
module tmpr_palette (
    input  logic              clk,
    input  tmpr_pkg::pal_wr_t wr,
    input  logic              rd_en,
    input  logic [7:0]        raddr,
    output logic [23:0]       rdata
);
    import tmpr_pkg::*;

    logic [23:0] mem [PAL_DEPTH];
    logic [23:0] rdata_reg;
    logic        wr_ok;

    assign wr_ok = (32'(wr.addr) < PAL_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_ok)
        begin
            mem[wr.addr[7:0]] <= wr.color;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
